// File: rtl/lruc_pkg.sv
`default_nettype none

package lruc_pkg;

  localparam int KEY_W         = 64;
  localparam int CFG_W         = 6;
  localparam int COST_W        = 3;
  localparam int TOTAL_W       = 32;
  localparam int APB_AW        = 2;
  localparam int APB_DW        = 32;

  localparam int WAYS_DEF      = 32;
  localparam int KEY_BYTES_DEF = 8;

  localparam logic [COST_W-1:0]  COST_HIT   = 3'd1;
  localparam logic [COST_W-1:0]  COST_MISS  = 3'd5;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0]   SIZE_RESET = 6'd32;

  // register map (byte addresses)
  localparam logic [APB_AW-1:0] ADDR_CACHE_SIZE = 2'd0;

  // control from the top level to the cell chain
  typedef struct packed {
    logic look;      // compare the staged key in every cell
    logic upd;       // apply the shift for the compared key
    logic store_en;  // capacity above zero
    logic full;      // occupancy at capacity
  } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lruc_cell.sv
`default_nettype none

module lruc_cell #(
  parameter int KW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          look,
  input  wire logic          ld,
  input  wire logic          live,
  input  wire logic [KW-1:0] cmp_key,
  input  wire logic [KW-1:0] shift_in,
  output logic      [KW-1:0] key,
  output logic               match
);

  // key storage: takes the neighbor's key (or the new key in the first cell)
  always_ff @(posedge clk) begin
    if (ld) begin
      key <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (look) begin
      match <= live && (key == cmp_key);
    end
  end

endmodule

`default_nettype wire

// File: rtl/lruc_chain.sv
`default_nettype none

module lruc_chain #(
  parameter int WAYS = lruc_pkg::WAYS_DEF,
  parameter int KW   = 8 * lruc_pkg::KEY_BYTES_DEF,
  parameter int CW   = $clog2(WAYS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lruc_pkg::chain_ctrl_t ctrl,
  input  wire logic [CW-1:0]         count,
  input  wire logic [KW-1:0]         cmp_key,
  input  wire logic [KW-1:0]         new_key,
  output logic                       hit
);

  // cell 0 is most recent, cell count-1 is oldest
  logic [KW-1:0]   keys [WAYS];
  logic [KW-1:0]   links [WAYS];
  logic [WAYS-1:0] live;
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] ld;
  logic [WAYS-1:0] ld_hit;
  logic [WAYS-1:0] ld_miss;

  assign links[0] = new_key;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign links[i] = keys[i-1];
    end
    assign live[i] = (count > CW'(i));

    lruc_cell #(
      .KW (KW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .look     (ctrl.look),
      .ld       (ld[i]),
      .live     (live[i]),
      .cmp_key  (cmp_key),
      .shift_in (links[i]),
      .key      (keys[i]),
      .match    (match[i])
    );
  end

  // at most one cell matches, at p, so cells 0..p are m | (m - 1)
  assign hit     = |match;
  assign ld_hit  = match | (match - WAYS'(1));
  // miss: full shifts the occupied cells, else one cell more
  assign ld_miss = ctrl.full ? live : WAYS'({live, 1'b1});

  always_comb begin
    ld = '0;
    if (ctrl.upd) begin
      if (hit) begin
        ld = ld_hit;
      end else if (ctrl.store_en) begin
        ld = ld_miss;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lru_cache_hit_miss_cost_core.sv
`default_nettype none

// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+-------------------------------------------
// request  | in_valid   | in_stall   | key
// result   | out_valid  | out_stall  | hit, access_cost, evicted, total_cost
// config   | psel/penable/pwrite (APB) | pready = 1 | paddr, pwdata, prdata
//
// A request passes through a compare stage, where every cell checks its key
// against the staged key, and then a shift stage, where the cell chain moves one step.
// The next request is taken while the one before is in its compare stage and waits
// through that request's shift stage, so a new request can be accepted before the
// last one is done. in_stall is high while both stages hold a request.
// A stalled result holds the shift stage, which in turn holds the compare stage.
// rst clears occupancy and the running total and sets cache_size to 32; no
// clearing pass over the cells is needed, since cells past the count never match.

module lru_cache_hit_miss_cost_core #(
  parameter int WAYS      = lruc_pkg::WAYS_DEF,
  parameter int KEY_BYTES = lruc_pkg::KEY_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lruc_pkg::KEY_W-1:0]    key,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic [lruc_pkg::COST_W-1:0]        access_cost,
  output logic                               evicted,
  output logic [lruc_pkg::TOTAL_W-1:0]       total_cost,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lruc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [lruc_pkg::APB_DW-1:0]   pwdata,
  output logic [lruc_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int CW = $clog2(WAYS + 1);
  localparam int MW = (CW > lruc_pkg::CFG_W) ? CW : lruc_pkg::CFG_W;

  logic [lruc_pkg::CFG_W-1:0]   cache_size;
  logic [CW-1:0]                count;
  logic [lruc_pkg::TOTAL_W-1:0] running_total;
  logic [lruc_pkg::TOTAL_W-1:0] total_next;

  logic                         look_v;
  logic                         upd_v;
  logic [KW-1:0]                look_key;
  logic [KW-1:0]                upd_key;
  logic [KW-1:0]                folded;

  logic                         accept;
  logic                         look_fire;
  logic                         upd_fire;
  logic                         cfg_wr;

  logic [MW-1:0]                cap_wide;
  logic [CW-1:0]                cap;
  logic                         chain_hit;
  logic [lruc_pkg::COST_W-1:0]  cost;
  lruc_pkg::chain_ctrl_t        ctrl;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr == lruc_pkg::ADDR_CACHE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_size <= lruc_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      cache_size <= pwdata[lruc_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lruc_pkg::ADDR_CACHE_SIZE) begin
      prdata = lruc_pkg::APB_DW'(cache_size);
    end
  end

  // capacity saturates at the number of cells
  assign cap_wide = (MW'(cache_size) > MW'(WAYS)) ? MW'(WAYS) : MW'(cache_size);
  assign cap      = cap_wide[CW-1:0];

  // -------------------------------------------------------------- handshake
  // compare only once the shift stage is empty, so cells are current
  assign look_fire = look_v && !upd_v;
  assign upd_fire  = upd_v && (!out_valid || !out_stall);
  assign in_stall  = look_v && !look_fire;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      look_v <= 1'b0;
    end else if (accept) begin
      look_v <= 1'b1;
    end else if (look_fire) begin
      look_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_v <= 1'b0;
    end else if (look_fire) begin
      upd_v <= 1'b1;
    end else if (upd_fire) begin
      upd_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= upd_fire || (out_valid && out_stall);
    end
  end

  // ------------------------------------------------------------ key staging
  // fold A..Z to lower case; bytes past KEY_BYTES are dropped
  always_comb begin
    logic [7:0] b;
    b = '0;
    for (int k = 0; k < KEY_BYTES; k++) begin
      b = key[8*k +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      folded[8*k +: 8] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      look_key <= folded;
    end
    if (look_fire) begin
      upd_key <= look_key;
    end
  end

  // ------------------------------------------------------------- cell chain
  assign ctrl.look     = look_fire;
  assign ctrl.upd      = upd_fire;
  assign ctrl.store_en = (cap != '0);
  assign ctrl.full     = (count >= cap);

  lruc_chain #(
    .WAYS (WAYS),
    .KW   (KW),
    .CW   (CW)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .count   (count),
    .cmp_key (look_key),
    .new_key (upd_key),
    .hit     (chain_hit)
  );

  // ----------------------------------------------------- occupancy and cost
  assign cost = chain_hit ? lruc_pkg::COST_HIT : lruc_pkg::COST_MISS;
  assign total_next = (running_total > (lruc_pkg::TOTAL_MAX - lruc_pkg::TOTAL_W'(cost)))
                      ? lruc_pkg::TOTAL_MAX
                      : running_total + lruc_pkg::TOTAL_W'(cost);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      count         <= '0;
      running_total <= '0;
    end else if (upd_fire) begin
      running_total <= total_next;
      if (!chain_hit && ctrl.store_en && !ctrl.full) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      hit         <= chain_hit;
      access_cost <= cost;
      evicted     <= !chain_hit && ctrl.store_en && ctrl.full;
    end
  end

  // total moves on a shift, which waits for the result to be taken, and clears on a cache_size write
  assign total_cost = running_total;

endmodule

`default_nettype wire

// File: rtl/lruc_checker.sv
`default_nettype none

module lruc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         hit,
  input wire logic [lruc_pkg::COST_W-1:0]  access_cost,
  input wire logic                         evicted,
  input wire logic [lruc_pkg::TOTAL_W-1:0] total_cost
);

  a_cost_matches_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit && access_cost == lruc_pkg::COST_HIT)
               || (!hit && access_cost == lruc_pkg::COST_MISS))
    else $error("access_cost disagrees with hit");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_cost != '0))
    else $error("result shows an empty running total");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(total_cost) && $stable(hit)))
    else $error("stalled result changed");

endmodule

bind lru_cache_hit_miss_cost_core lruc_checker u_lruc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .hit         (hit),
  .access_cost (access_cost),
  .evicted     (evicted),
  .total_cost  (total_cost)
);

`default_nettype wire
